[rtl/pcg32_random_generator_assert.svh]
// Assertion macros shared by the PCG32 generator modules.
`ifndef PCG32_RANDOM_GENERATOR_ASSERT_SVH
`define PCG32_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pcg_pkg.sv]
// Shared types, codes, constants and the output permutation of the PCG32 generator.
package pcg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_START,
    ST_STEP_WAIT,
    ST_THR_WAIT,
    ST_REM_WAIT,
    ST_FINISH
  } pcg_state_t;

  localparam logic [2:0] FUNC_DRAW32 = 3'd0;
  localparam logic [2:0] FUNC_DRAW64 = 3'd1;
  localparam logic [2:0] FUNC_RANGE  = 3'd2;
  localparam logic [2:0] FUNC_UNIT   = 3'd3;
  localparam logic [2:0] FUNC_SIGNED = 3'd4;

  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_SEED = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_MULT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_INCR = 2'd2;

  localparam logic [63:0] SeedDefault = 64'd0;
  localparam logic [63:0] MultDefault = 64'd6364136223846793005;
  localparam logic [63:0] IncrDefault = 64'd1442695040888963407;

  localparam int MulDigitW = 16;
  localparam int MulSteps  = 64 / MulDigitW;
  localparam int MulCntW   = $clog2(MulSteps);

  localparam int DivW    = 32;
  localparam int DivCntW = $clog2(DivW);

  localparam int TryW = 6;
  localparam logic [TryW-1:0] TryLast = 6'd63;

  localparam logic [24:0] FracOne = 25'h1000000;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } pcg_mul_rsp_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } pcg_div_rsp_t;

  // XSH-RR: xorshift high bits, then rotate right by the top five state bits.
  function automatic logic [31:0] pcg_permute(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] word;
    logic [4:0]  rot;
    logic [63:0] both;
    x    = s ^ (s >> 18);
    word = x[58:27];
    rot  = s[63:59];
    both = {word, word} >> rot;
    return both[31:0];
  endfunction

endpackage

[rtl/pcg_mul.sv]
// Digit-serial 64-bit multiply-add: product = a * b + c mod 2^64.
module pcg_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  input  logic [63:0]           c,
  output pcg_pkg::pcg_mul_rsp_t rsp
);

  logic [63:0]                   acc;
  logic [63:0]                   mcand;
  logic [63:0]                   mplier;
  logic [pcg_pkg::MulCntW-1:0]   cnt;
  logic                          busy;
  logic                          done;
  logic [63:0]                   part;

  // Only the low 64 bits of each partial product reach the sum.
  assign part = mcand * 64'(mplier[pcg_pkg::MulDigitW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == pcg_pkg::MulCntW'(pcg_pkg::MulSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= c;
      mcand  <= a;
      mplier <= b;
      cnt    <= '0;
    end else if (busy) begin
      acc    <= acc + part;
      mcand  <= mcand << pcg_pkg::MulDigitW;
      mplier <= mplier >> pcg_pkg::MulDigitW;
      cnt    <= cnt + 1'b1;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

`include "pcg32_random_generator_assert.svh"
  `PCG_ASSERT(a_mul_start_idle, start, !busy, "multiply started while busy")

endmodule

[rtl/pcg_div.sv]
// Restoring 32-bit divider, one bit per cycle, remainder only.
module pcg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcg_pkg::DivW-1:0]   dividend,
  input  logic [pcg_pkg::DivW-1:0]   divisor,
  output pcg_pkg::pcg_div_rsp_t      rsp
);

  logic [pcg_pkg::DivW-1:0]    rem;
  logic [pcg_pkg::DivW-1:0]    dvd;
  logic [pcg_pkg::DivW-1:0]    dsr;
  logic [pcg_pkg::DivCntW-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [pcg_pkg::DivW:0]      trial;
  logic [pcg_pkg::DivW:0]      diff;

  assign trial = {rem, dvd[pcg_pkg::DivW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == pcg_pkg::DivCntW'(pcg_pkg::DivW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
      cnt <= '0;
    end else if (busy) begin
      // Subtract when the shifted remainder reaches the divisor.
      if (!diff[pcg_pkg::DivW]) begin
        rem <= diff[pcg_pkg::DivW-1:0];
      end else begin
        rem <= trial[pcg_pkg::DivW-1:0];
      end
      dvd <= dvd << 1;
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

`include "pcg32_random_generator_assert.svh"
  `PCG_ASSERT(a_div_start_idle, start, !busy, "divide started while busy")

endmodule

[rtl/pcg32_random_generator.sv]
// Top level of the PCG32 XSH-RR generator: sequencer, state and registers.
//
// PCG32 XSH-RR generator with a 64-bit LCG state. Each request item on the
// s_axis side gives exactly one result item on m_axis. Every 32-bit draw
// permutes the current state and advances it with state * multiplier +
// increment, computed by one shared 64-bit multiply-add unit that takes a
// 16-bit digit of the multiplier per cycle. A draw starts the unit, runs
// four digit steps and hands over the product. A ranged draw uses one
// shared restoring divider (one bit per cycle) twice, for the rejection
// threshold and for the final remainder, plus one draw when the first is
// kept and one more per rejected draw (at most 64 draws). A zero bound or
// an unused func goes straight to its result without a draw. The block
// takes one item at a time; a finished result sits in the output register
// while the next item is taken, and a result that finds the output
// register still full waits until it is free. After reset and after every
// seed write the block re-seeds with one generator step, during which it
// takes no item and no configuration write.
module pcg32_random_generator (
  input  logic                            clk,
  input  logic                            rst,
  // Request item.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,   // [31:0] low, [63:32] high
  input  logic [2:0]                      s_axis_tuser,   // [2:0] func
  // Result item.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [95:0]                     m_axis_tdata,   // [63:0] value,
                                                          // [88:64] signed_fraction, zero pad
  output logic                            m_axis_tuser,   // [0] range_error
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcg_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);

  pcg_pkg::pcg_state_t fsm;
  pcg_pkg::pcg_state_t fsm_next;

  logic [63:0] mult;
  logic [63:0] incr;
  logic [63:0] lcg_state;
  logic        seeding;

  logic [2:0]              func_q;
  logic [31:0]             low_q;
  logic [31:0]             bound_q;
  logic [31:0]             thr;
  logic [31:0]             draw;
  logic [pcg_pkg::TryW-1:0] tries;
  logic                    second;

  logic [63:0] res_value;
  logic [24:0] res_sfrac;
  logic        res_err;

  logic        m_valid;
  logic [63:0] m_value;
  logic [24:0] m_sfrac;
  logic        m_err;

  logic        in_accept;
  logic        cfg_accept;
  logic [2:0]  func_in;
  logic [31:0] low_in;
  logic [31:0] high_in;
  logic [31:0] bound_in;
  logic        range_take;
  logic        out_free;
  logic        div_wait;

  logic                  mul_start;
  pcg_pkg::pcg_mul_rsp_t mul_rsp;
  logic                  div_start;
  logic [31:0]           div_dividend;
  logic [31:0]           div_divisor;
  pcg_pkg::pcg_div_rsp_t div_rsp;

  assign func_in    = s_axis_tuser;
  assign low_in     = s_axis_tdata[31:0];
  assign high_in    = s_axis_tdata[63:32];
  assign bound_in   = high_in - low_in;
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  // Keep the draw when it clears the threshold or the last try is reached.
  assign range_take = (draw >= thr) || (tries == pcg_pkg::TryLast);
  assign out_free   = !m_valid || m_axis_tready;
  assign div_wait   = (fsm == pcg_pkg::ST_THR_WAIT) || (fsm == pcg_pkg::ST_REM_WAIT);

  pcg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (lcg_state),
    .b     (mult),
    .c     (incr),
    .rsp   (mul_rsp)
  );

  pcg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  // Next state.
  always_comb begin
    fsm_next = fsm;
    case (fsm)
      pcg_pkg::ST_IDLE: begin
        if (cfg_accept) begin
          if (cfg_index == pcg_pkg::CFG_SEED) begin
            fsm_next = pcg_pkg::ST_STEP_START;
          end
        end else if (in_accept) begin
          case (func_in)
            pcg_pkg::FUNC_DRAW32, pcg_pkg::FUNC_DRAW64,
            pcg_pkg::FUNC_UNIT, pcg_pkg::FUNC_SIGNED: begin
              fsm_next = pcg_pkg::ST_STEP_START;
            end
            pcg_pkg::FUNC_RANGE: begin
              fsm_next = (bound_in == '0) ? pcg_pkg::ST_FINISH : pcg_pkg::ST_THR_WAIT;
            end
            default: begin
              fsm_next = pcg_pkg::ST_FINISH;
            end
          endcase
        end
      end
      pcg_pkg::ST_STEP_START: begin
        fsm_next = pcg_pkg::ST_STEP_WAIT;
      end
      pcg_pkg::ST_STEP_WAIT: begin
        if (mul_rsp.done) begin
          if (seeding) begin
            fsm_next = pcg_pkg::ST_IDLE;
          end else if (func_q == pcg_pkg::FUNC_DRAW64 && !second) begin
            fsm_next = pcg_pkg::ST_STEP_START;
          end else if (func_q == pcg_pkg::FUNC_RANGE) begin
            fsm_next = range_take ? pcg_pkg::ST_REM_WAIT : pcg_pkg::ST_STEP_START;
          end else begin
            fsm_next = pcg_pkg::ST_FINISH;
          end
        end
      end
      pcg_pkg::ST_THR_WAIT: begin
        if (div_rsp.done) begin
          fsm_next = pcg_pkg::ST_STEP_START;
        end
      end
      pcg_pkg::ST_REM_WAIT: begin
        if (div_rsp.done) begin
          fsm_next = pcg_pkg::ST_FINISH;
        end
      end
      pcg_pkg::ST_FINISH: begin
        if (out_free) begin
          fsm_next = pcg_pkg::ST_IDLE;
        end
      end
      default: begin
        fsm_next = pcg_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshakes and unit controls.
  always_comb begin
    s_axis_tready = (fsm == pcg_pkg::ST_IDLE) && !rst;
    cfg_ready     = (fsm == pcg_pkg::ST_IDLE) && !rst && !s_axis_tvalid;
    mul_start     = (fsm == pcg_pkg::ST_STEP_START);
    div_start     = 1'b0;
    div_dividend  = draw;
    div_divisor   = bound_q;
    case (fsm)
      pcg_pkg::ST_IDLE: begin
        // Threshold pass: (2^32 - bound) mod bound.
        div_start    = in_accept && func_in == pcg_pkg::FUNC_RANGE && bound_in != '0;
        div_dividend = '0 - bound_in;
        div_divisor  = bound_in;
      end
      pcg_pkg::ST_STEP_WAIT: begin
        // Remainder pass on the kept draw.
        div_start = mul_rsp.done && !seeding && func_q == pcg_pkg::FUNC_RANGE && range_take;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= pcg_pkg::ST_STEP_START;
      seeding   <= 1'b1;
      mult      <= pcg_pkg::MultDefault;
      incr      <= pcg_pkg::IncrDefault;
      // First seeding step from a zero state leaves just increment; add seed.
      lcg_state <= pcg_pkg::IncrDefault + pcg_pkg::SeedDefault;
      m_valid   <= 1'b0;
    end else begin
      fsm <= fsm_next;
      // Drop the result once taken, unless a new one is loaded below.
      if (m_axis_tready && fsm != pcg_pkg::ST_FINISH) begin
        m_valid <= 1'b0;
      end
      case (fsm)
        pcg_pkg::ST_IDLE: begin
          if (cfg_accept) begin
            case (cfg_index)
              pcg_pkg::CFG_SEED: begin
                lcg_state <= incr + cfg_data;
                seeding   <= 1'b1;
              end
              pcg_pkg::CFG_MULT: mult <= cfg_data;
              pcg_pkg::CFG_INCR: incr <= cfg_data;
              default: begin
                // Drop writes beyond the register list.
              end
            endcase
          end else if (in_accept) begin
            func_q    <= func_in;
            low_q     <= low_in;
            bound_q   <= bound_in;
            tries     <= '0;
            second    <= 1'b0;
            res_value <= '0;
            res_sfrac <= '0;
            res_err   <= (func_in == pcg_pkg::FUNC_RANGE) && (bound_in == '0);
          end
        end
        pcg_pkg::ST_STEP_START: begin
          draw <= pcg_pkg::pcg_permute(lcg_state);
        end
        pcg_pkg::ST_STEP_WAIT: begin
          if (mul_rsp.done) begin
            lcg_state <= mul_rsp.product;
            if (seeding) begin
              seeding <= 1'b0;
            end else begin
              case (func_q)
                pcg_pkg::FUNC_DRAW32: res_value <= {32'd0, draw};
                pcg_pkg::FUNC_DRAW64: begin
                  // First draw is the high word.
                  if (!second) begin
                    res_value[63:32] <= draw;
                    second           <= 1'b1;
                  end else begin
                    res_value[31:0] <= draw;
                  end
                end
                pcg_pkg::FUNC_RANGE: begin
                  if (!range_take) begin
                    tries <= tries + 1'b1;
                  end
                end
                pcg_pkg::FUNC_UNIT:   res_value <= {40'd0, draw[31:8]};
                pcg_pkg::FUNC_SIGNED: res_sfrac <= {draw[31:8], 1'b0} - pcg_pkg::FracOne;
                default: begin
                  // Unused funcs never draw.
                end
              endcase
            end
          end
        end
        pcg_pkg::ST_THR_WAIT: begin
          if (div_rsp.done) begin
            thr <= div_rsp.rem;
          end
        end
        pcg_pkg::ST_REM_WAIT: begin
          if (div_rsp.done) begin
            res_value <= {32'd0, low_q + div_rsp.rem};
          end
        end
        pcg_pkg::ST_FINISH: begin
          // Load the output register once it is free.
          if (out_free) begin
            m_valid <= 1'b1;
            m_value <= res_value;
            m_sfrac <= res_sfrac;
            m_err   <= res_err;
          end
        end
        default: begin
          // Hold.
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'd0, m_sfrac, m_value};
  assign m_axis_tuser  = m_err;

`include "pcg32_random_generator_assert.svh"
  `PCG_ASSERT(a_mul_done_waited, mul_rsp.done, fsm == pcg_pkg::ST_STEP_WAIT, "stray mul done")
  `PCG_ASSERT(a_div_done_waited, div_rsp.done, div_wait, "stray div done")
  `PCG_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready, "ready after accept")

endmodule
